@@ sv/ptc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg: shared types, constants and the arctangent table
// Widths of the pipeline lanes, the cell lane structs and the
// elaboration-time build of the octant arctangent table.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int COORD_BITS  = 12;
  localparam int MAG_W       = COORD_BITS;       // |offset| up to 2^(COORD_BITS-1)
  localparam int ATAN_STEPS  = 256;
  localparam int IDX_W       = 9;                // index 0..ATAN_STEPS
  localparam int ANG_W       = 11;               // signed angle -512..512
  localparam int SQ_W        = 24;               // ax^2 + ay^2
  localparam int RAD_N_W     = 40;               // sq << 16
  localparam int ROOT_W      = RAD_N_W / 2;
  localparam int SREM_W      = ROOT_W + 3;
  localparam int NUM_W       = 39;               // depth_scale << 8
  localparam int QUO_W       = 28;
  localparam int CFG_W       = 31;
  localparam int PAN_W       = 24;
  localparam int RADIUS_MIN  = 12 * 256;

  localparam int ATAN_CELLS  = IDX_W - 1;
  localparam int SQRT_CELLS  = ROOT_W;
  localparam int DEPTH_CELLS = NUM_W;
  localparam int PIPE_LATENCY = 2 + ATAN_CELLS + 1 + SQRT_CELLS + 1 + DEPTH_CELLS + 1;

  typedef enum logic [2:0] {
    REG_DEPTH_SCALE = 3'd0,
    REG_ANGLE_PAN   = 3'd1,
    REG_DEPTH_PAN   = 3'd2,
    REG_BAND_NEAR   = 3'd3,
    REG_BAND_SECOND = 3'd4,
    REG_BAND_THIRD  = 3'd5,
    REG_BAND_FOURTH = 3'd6,
    REG_CORE_LIMIT  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] offset_x;
    logic signed [COORD_BITS-1:0] offset_y;
  } request_t;

  typedef struct packed {
    logic signed [31:0] angle_coord;
    logic signed [31:0] depth_coord;
    logic [2:0]         shade_level;
  } result_t;

  // Data carried alongside every cell of the chain
  typedef struct packed {
    logic             sx;
    logic             sy;
    logic             swap;
    logic             zero;
    logic [ANG_W-1:0] angle;
    logic [SQ_W-1:0]  sq;
  } side_t;

  typedef struct packed {
    logic             valid;
    side_t            side;
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] den;
    logic [IDX_W-1:0] q;
  } atan_lane_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic [RAD_N_W-1:0] n;
    logic [ROOT_W-1:0]  q;
    logic [SREM_W-1:0]  rem;
  } sqrt_lane_t;

  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] den;
    logic [ROOT_W-1:0] rem;
    logic [QUO_W-1:0]  q;
  } depth_lane_t;

  typedef logic [7:0] atan_rom_t [0:ATAN_STEPS];

  typedef longint angle_tab_t [0:20];
  localparam angle_tab_t CORDIC_ANGLES = '{
    134217728, 79233353, 41864727, 21251189, 10666835, 5338616, 2669960,
    1335061, 667541, 333772, 166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163
  };

  function automatic longint shr_sym(longint v, int s);
    return (v >= 0) ? (v >>> s) : -((-v) >>> s);
  endfunction

  // One table entry: CORDIC vectoring with 20 fraction bits, rounded half up
  function automatic logic [7:0] atan_entry(int i);
    longint x, y, z, xs, ys;
    int j;
    x = longint'(ATAN_STEPS) <<< 24;
    y = longint'(i) <<< 24;
    z = 0;
    for (j = 0; j < 21; j++) begin
      xs = shr_sym(x, j);
      ys = shr_sym(y, j);
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + CORDIC_ANGLES[j];
      end else begin
        x = x - ys; y = y + xs; z = z - CORDIC_ANGLES[j];
      end
    end
    z = z + (longint'(1) <<< 19);
    if (z < 0) z = 0;
    z = z >>> 20;
    if (z > 255) z = 255;
    return z[7:0];
  endfunction

  function automatic atan_rom_t build_atan_rom();
    atan_rom_t t;
    int i;
    for (i = 0; i <= ATAN_STEPS; i++) t[i] = atan_entry(i);
    return t;
  endfunction

  localparam atan_rom_t ATAN_ROM = build_atan_rom();

endpackage

@@ sv/ptc_atan_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_atan_cell: one quotient bit of the octant ratio
// Doubles the partial remainder, subtracts the larger magnitude when it fits.
// ----------------------------------------------------------------------------
module ptc_atan_cell import ptc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  atan_lane_t lane_in,
  output atan_lane_t lane_out
);

  logic [MAG_W:0] trial;
  logic           take;
  atan_lane_t     lane_next;

  // Shift, compare, subtract
  always_comb begin
    trial     = {lane_in.rem, 1'b0};
    take      = (trial >= {1'b0, lane_in.den});
    lane_next = lane_in;
    lane_next.rem = take ? MAG_W'(trial - {1'b0, lane_in.den}) : trial[MAG_W-1:0];
    lane_next.q   = {lane_in.q[IDX_W-2:0], take};
  end

  // Advance to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out <= lane_next;
    end
  end

endmodule

@@ sv/ptc_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_sqrt_cell: one root bit of the radius square root
// Brings down two radicand bits and tries the next root bit.
// ----------------------------------------------------------------------------
module ptc_sqrt_cell import ptc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  sqrt_lane_t lane_in,
  output sqrt_lane_t lane_out
);

  logic [SREM_W-1:0] r;
  logic [SREM_W-1:0] trial;
  logic              take;
  sqrt_lane_t        lane_next;

  // Try root bit, keep remainder
  always_comb begin
    r         = {lane_in.rem[SREM_W-3:0], lane_in.n[RAD_N_W-1:RAD_N_W-2]};
    trial     = {1'b0, lane_in.q, 2'b01};
    take      = (r >= trial);
    lane_next = lane_in;
    lane_next.rem = take ? (r - trial) : r;
    lane_next.q   = {lane_in.q[ROOT_W-2:0], take};
    lane_next.n   = {lane_in.n[RAD_N_W-3:0], 2'b00};
  end

  // Advance to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out <= lane_next;
    end
  end

endmodule

@@ sv/ptc_depth_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_depth_cell: one quotient bit of depth over radius
// Restoring division step on the scaled depth constant.
// ----------------------------------------------------------------------------
module ptc_depth_cell import ptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  depth_lane_t lane_in,
  output depth_lane_t lane_out
);

  logic [ROOT_W:0] r;
  logic            take;
  depth_lane_t     lane_next;

  // Bring down a numerator bit, subtract when it fits
  always_comb begin
    r         = {lane_in.rem, lane_in.num[NUM_W-1]};
    take      = (r >= {1'b0, lane_in.den});
    lane_next = lane_in;
    lane_next.rem = take ? ROOT_W'(r - {1'b0, lane_in.den}) : r[ROOT_W-1:0];
    lane_next.q   = {lane_in.q[QUO_W-2:0], take};
    lane_next.num = {lane_in.num[NUM_W-2:0], 1'b0};
  end

  // Advance to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out <= lane_next;
    end
  end

endmodule

@@ sv/polar_texture_coordinate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_texture_coordinate: tunnel texture coordinates from a screen offset
// Octant arctangent, radius square root and depth division run as rows of
// one-bit cells; each request walks the rows one cell per cycle.
//
//   channel  | ports                         | transfer
//   request  | start, busy, request          | start && !busy
//   result   | done, result                  | done, one cycle
//   config   | cfg_we, cfg_index, cfg_data   | cfg_we
//
// One request per cycle; each request walks 8 ratio cells, 20 root cells and
// 39 divide cells in turn. busy stays low. Reset clears all lane valid bits
// and loads the register defaults. The receiver cannot stall; results are
// strobed once.
// ----------------------------------------------------------------------------
module polar_texture_coordinate import ptc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  request_t         request,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             done,
  output result_t          result
);

  // Configuration registers
  logic [CFG_W-1:0] depth_scale, band_near, band_second, band_third, band_fourth;
  logic [CFG_W-1:0] core_limit;
  logic [PAN_W-1:0] angle_pan, depth_pan;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_scale <= CFG_W'(196608000);
      angle_pan   <= '0;
      depth_pan   <= '0;
      band_near   <= CFG_W'(2048000);
      band_second <= CFG_W'(2656864);
      band_third  <= CFG_W'(3640888);
      band_fourth <= CFG_W'(5173894);
      core_limit  <= CFG_W'(9830400);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_DEPTH_SCALE: depth_scale <= cfg_data;
        REG_ANGLE_PAN:   angle_pan   <= cfg_data[PAN_W-1:0];
        REG_DEPTH_PAN:   depth_pan   <= cfg_data[PAN_W-1:0];
        REG_BAND_NEAR:   band_near   <= cfg_data;
        REG_BAND_SECOND: band_second <= cfg_data;
        REG_BAND_THIRD:  band_third  <= cfg_data;
        REG_BAND_FOURTH: band_fourth <= cfg_data;
        REG_CORE_LIMIT:  core_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage A: magnitudes and signs
  logic             a_valid;
  logic             a_sx, a_sy;
  logic [MAG_W-1:0] a_ax, a_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
      a_sx    <= request.offset_x[COORD_BITS-1];
      a_sy    <= request.offset_y[COORD_BITS-1];
      a_ax    <= request.offset_x[COORD_BITS-1] ?
                 (~request.offset_x + 1'b1) : request.offset_x;
      a_ay    <= request.offset_y[COORD_BITS-1] ?
                 (~request.offset_y + 1'b1) : request.offset_y;
    end
  end

  // Stage B: octant setup and squared radius
  logic             b_swap, b_eq;
  logic [MAG_W-1:0] b_min, b_max;
  logic [SQ_W-1:0]  b_sq;
  atan_lane_t       atan_lane [0:ATAN_CELLS];

  always_comb begin
    b_swap = (a_ax < a_ay);
    b_min  = b_swap ? a_ax : a_ay;
    b_max  = b_swap ? a_ay : a_ax;
    b_eq   = (b_min == b_max) && (b_max != '0);
    b_sq   = SQ_W'(SQ_W'(a_ax) * SQ_W'(a_ax)) + SQ_W'(SQ_W'(a_ay) * SQ_W'(a_ay));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      atan_lane[0].valid <= 1'b0;
    end else begin
      atan_lane[0].valid      <= a_valid;
      atan_lane[0].side.sx    <= a_sx;
      atan_lane[0].side.sy    <= a_sy;
      atan_lane[0].side.swap  <= b_swap;
      atan_lane[0].side.zero  <= (b_max == '0);
      atan_lane[0].side.angle <= '0;
      atan_lane[0].side.sq    <= b_sq;
      atan_lane[0].rem        <= b_eq ? '0 : b_min;
      atan_lane[0].den        <= b_max;
      atan_lane[0].q          <= {{(IDX_W-1){1'b0}}, b_eq};
    end
  end

  // Ratio cells
  for (genvar i = 0; i < ATAN_CELLS; i++) begin : g_atan
    ptc_atan_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_in  (atan_lane[i]),
      .lane_out (atan_lane[i+1])
    );
  end

  // Stage C: table lookup and octant reflection
  atan_lane_t       atan_end;
  logic [7:0]       c_rv;
  logic [9:0]       c_a0, c_a1;
  logic [ANG_W-1:0] c_a11, c_angle;
  side_t            c_side;
  sqrt_lane_t       sqrt_lane [0:SQRT_CELLS];

  assign atan_end = atan_lane[ATAN_CELLS];

  always_comb begin
    c_rv    = ATAN_ROM[atan_end.q];
    c_a0    = atan_end.side.swap ? (10'd256 - 10'(c_rv)) :
              (atan_end.side.zero ? 10'd0 : 10'(c_rv));
    c_a1    = atan_end.side.sx ? (10'd512 - c_a0) : c_a0;
    c_a11   = {1'b0, c_a1};
    c_angle = atan_end.side.sy ? (~c_a11 + 1'b1) : c_a11;
    c_side  = atan_end.side;
    c_side.angle = c_angle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_lane[0].valid <= 1'b0;
    end else begin
      sqrt_lane[0].valid <= atan_end.valid;
      sqrt_lane[0].side  <= c_side;
      sqrt_lane[0].n     <= {atan_end.side.sq, 16'b0};
      sqrt_lane[0].q     <= '0;
      sqrt_lane[0].rem   <= '0;
    end
  end

  // Root cells
  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    ptc_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_in  (sqrt_lane[i]),
      .lane_out (sqrt_lane[i+1])
    );
  end

  // Stage D: clamp radius, load divider
  sqrt_lane_t  sqrt_end;
  depth_lane_t depth_lane [0:DEPTH_CELLS];

  assign sqrt_end = sqrt_lane[SQRT_CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_lane[0].valid <= 1'b0;
    end else begin
      depth_lane[0].valid <= sqrt_end.valid;
      depth_lane[0].side  <= sqrt_end.side;
      depth_lane[0].num   <= {depth_scale, 8'b0};
      depth_lane[0].den   <= (sqrt_end.q < ROOT_W'(RADIUS_MIN)) ?
                             ROOT_W'(RADIUS_MIN) : sqrt_end.q;
      depth_lane[0].rem   <= '0;
      depth_lane[0].q     <= '0;
    end
  end

  // Divide cells
  for (genvar i = 0; i < DEPTH_CELLS; i++) begin : g_depth
    ptc_depth_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_in  (depth_lane[i]),
      .lane_out (depth_lane[i+1])
    );
  end

  // Stage E: shade bands, pans, result register
  depth_lane_t      depth_end;
  logic [CFG_W-1:0] raw;
  logic [2:0]       shade;

  assign depth_end = depth_lane[DEPTH_CELLS];
  assign raw       = CFG_W'(depth_end.q);

  always_comb begin
    if (raw > core_limit)        shade = 3'd5;
    else if (raw <= band_near)   shade = 3'd0;
    else if (raw <= band_second) shade = 3'd1;
    else if (raw <= band_third)  shade = 3'd2;
    else if (raw <= band_fourth) shade = 3'd3;
    else                         shade = 3'd4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done               <= depth_end.valid;
      result.angle_coord <= ({{(32-ANG_W){depth_end.side.angle[ANG_W-1]}},
                             depth_end.side.angle} << 14) + 32'(angle_pan);
      result.depth_coord <= 32'(depth_end.q) + 32'(depth_pan);
      result.shade_level <= shade;
    end
  end

endmodule

@@ sv/ptc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_checker: port-level checks for polar_texture_coordinate
// Fixed latency, never busy, quiet after reset, legal shade levels.
// ----------------------------------------------------------------------------
module ptc_checker import ptc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // Every request comes back after the fixed latency
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("result missing after request");

  // Never hold off a request
  assert property (@(posedge clk) !busy)
    else $error("busy raised");

  // No result in the cycle after reset
  assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result right after reset");

  // Shade level stays in range
  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.shade_level <= 3'd5))
    else $error("shade level out of range");

endmodule

bind polar_texture_coordinate ptc_checker u_ptc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for polar_texture_coordinate
// Drives screen offsets through the start/busy command port and checks every
// strobed result against a behavioral model of the octant arctangent, radius
// square root, depth division and shade banding. Registers are rewritten
// between phases while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb;
  import ptc_pkg::*;

  localparam int DRAIN_CYCLES = PIPE_LATENCY + 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  request_t         request;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             done;
  result_t          result;

  polar_texture_coordinate u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  // Shadow of the register file and the arctangent table
  logic [7:0]       atan_tab [0:ATAN_STEPS];
  logic [30:0]      sh_depth_scale, sh_near, sh_second, sh_third, sh_fourth, sh_core;
  logic [23:0]      sh_angle_pan, sh_depth_pan;

  result_t          coord_queue [$];
  int               fail_count;
  int               cycle_count;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic        has_exp;
    result_t     exp_res;
  } stim_row_t;

  // Build one arctangent entry by CORDIC vectoring, 20 fraction bits
  function automatic logic [7:0] cordic_atan(int i);
    longint steps [0:20] = '{134217728, 79233353, 41864727, 21251189, 10666835,
      5338616, 2669960, 1335061, 667541, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163};
    longint x, y, z, xs, ys;
    x = longint'(ATAN_STEPS) <<< 24;
    y = longint'(i) <<< 24;
    z = 0;
    for (int j = 0; j < 21; j++) begin
      xs = (x >= 0) ? (x >>> j) : -((-x) >>> j);
      ys = (y >= 0) ? (y >>> j) : -((-y) >>> j);
      if (y > 0) begin
        x += ys; y -= xs; z += steps[j];
      end else begin
        x -= ys; y += xs; z -= steps[j];
      end
    end
    z += longint'(1) <<< 19;
    if (z < 0) z = 0;
    z = z >>> 20;
    if (z > 255) z = 255;
    return z[7:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic int octant_entry(int num, int den);
    int idx;
    idx = (num * ATAN_STEPS) / den;
    if (idx > ATAN_STEPS) idx = ATAN_STEPS;
    return atan_tab[idx];
  endfunction

  // Compute tunnel coordinates for one offset
  function automatic result_t tunnel_coords(logic [11:0] xr, logic [11:0] yr);
    result_t r;
    int x, y, ax, ay, ang;
    longint unsigned sq, r8, raw;
    logic [2:0] shade;
    logic [31:0] angle_w, raw_w;
    x = $signed(xr);
    y = $signed(yr);
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    if (ax >= ay) ang = ax != 0 ? octant_entry(ay, ax) : 0;
    else ang = 256 - octant_entry(ax, ay);
    if (x < 0) ang = 512 - ang;
    if (y < 0) ang = -ang;
    sq = longint'(ax) * ax + longint'(ay) * ay;
    r8 = int_sqrt(sq << 16);
    if (r8 < RADIUS_MIN) r8 = RADIUS_MIN;
    raw = (longint'(sh_depth_scale) << 8) / r8;
    if (raw > sh_core) shade = 3'd5;
    else if (raw <= sh_near) shade = 3'd0;
    else if (raw <= sh_second) shade = 3'd1;
    else if (raw <= sh_third) shade = 3'd2;
    else if (raw <= sh_fourth) shade = 3'd3;
    else shade = 3'd4;
    angle_w = 32'(ang) << 14;
    raw_w = raw[31:0];
    r.angle_coord = angle_w + {8'd0, sh_angle_pan};
    r.depth_coord = raw_w + {8'd0, sh_depth_pan};
    r.shade_level = shade;
    return r;
  endfunction

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check each strobed result against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (coord_queue.size() == 0) begin
        $display("%0t unexpected result %h", $time, result);
        fail_count++;
      end else begin
        want = coord_queue.pop_front();
        if (result.angle_coord !== want.angle_coord) begin
          $display("%0t angle_coord exp %h got %h", $time, want.angle_coord,
                   result.angle_coord);
          fail_count++;
        end
        if (result.depth_coord !== want.depth_coord) begin
          $display("%0t depth_coord exp %h got %h", $time, want.depth_coord,
                   result.depth_coord);
          fail_count++;
        end
        if (result.shade_level !== want.shade_level) begin
          $display("%0t shade_level exp %0d got %0d", $time, want.shade_level,
                   result.shade_level);
          fail_count++;
        end
      end
    end
  end

  // Send one request, with a random gap ahead of it
  task automatic send_request(logic [11:0] x, logic [11:0] y, bit gaps);
    int gap;
    gap = 0;
    if (gaps) begin
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 60);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request.offset_x <= x;
    request.offset_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    coord_queue.push_back(tunnel_coords(x, y));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (coord_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register and its shadow; upper bits beyond the width drop
  task automatic write_reg(reg_index_t idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEPTH_SCALE: sh_depth_scale = val;
      REG_ANGLE_PAN:   sh_angle_pan = val[23:0];
      REG_DEPTH_PAN:   sh_depth_pan = val[23:0];
      REG_BAND_NEAR:   sh_near = val;
      REG_BAND_SECOND: sh_second = val;
      REG_BAND_THIRD:  sh_third = val;
      REG_BAND_FOURTH: sh_fourth = val;
      REG_CORE_LIMIT:  sh_core = val;
      default: ;
    endcase
  endtask

  function automatic logic [11:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 12'($urandom_range(0, 40)) - 12'd20;
      1: return 12'($urandom_range(0, 400)) - 12'd200;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      send_request(rand_coord(), rand_coord(), (i % 100) < 70);
    end
  endtask

  stim_row_t directed [$];

  function automatic stim_row_t row(logic [11:0] x, logic [11:0] y, bit known,
                                    logic [31:0] ang, logic [31:0] dep,
                                    logic [2:0] sh);
    stim_row_t s;
    s.x = x; s.y = y; s.has_exp = known;
    s.exp_res.angle_coord = ang;
    s.exp_res.depth_coord = dep;
    s.exp_res.shade_level = sh;
    return s;
  endfunction

  initial begin
    result_t typed;
    fail_count = 0;
    cycle_count = 0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_index = REG_DEPTH_SCALE;
    cfg_data = '0;
    for (int i = 0; i <= ATAN_STEPS; i++) atan_tab[i] = cordic_atan(i);
    sh_depth_scale = 31'd196608000;
    sh_angle_pan = '0;
    sh_depth_pan = '0;
    sh_near = 31'd2048000;
    sh_second = 31'd2656864;
    sh_third = 31'd3640888;
    sh_fourth = 31'd5173894;
    sh_core = 31'd9830400;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Origin: angle 0, radius clamped to 12, depth 196608000/12 -> core
    directed.push_back(row(12'd0, 12'd0, 1, 32'd0, 32'd16384000, 3'd5));
    // Positive x axis at radius 12 sits right at the clamp and gives the same result
    directed.push_back(row(12'd12, 12'd0, 1, 32'd0, 32'd16384000, 3'd5));
    directed.push_back(row(12'd0, 12'd12, 0, 0, 0, 0));
    directed.push_back(row(-12'sd12, 12'd0, 0, 0, 0, 0));
    directed.push_back(row(12'd0, -12'sd12, 0, 0, 0, 0));
    directed.push_back(row(12'd2047, 12'd2047, 0, 0, 0, 0));
    directed.push_back(row(12'h800, 12'h800, 0, 0, 0, 0));
    directed.push_back(row(12'h800, 12'd0, 0, 0, 0, 0));
    directed.push_back(row(12'd0, 12'h800, 0, 0, 0, 0));
    directed.push_back(row(12'd2047, 12'h800, 0, 0, 0, 0));
    directed.push_back(row(12'h800, 12'd2047, 0, 0, 0, 0));
    directed.push_back(row(-12'sd1, -12'sd1, 0, 0, 0, 0));
    directed.push_back(row(12'd100, 12'd100, 0, 0, 0, 0));
    directed.push_back(row(-12'sd100, 12'd100, 0, 0, 0, 0));
    directed.push_back(row(-12'sd100, -12'sd100, 0, 0, 0, 0));
    directed.push_back(row(12'd100, -12'sd100, 0, 0, 0, 0));
    directed.push_back(row(12'd2047, 12'd1, 0, 0, 0, 0));
    directed.push_back(row(12'd1, 12'd2047, 0, 0, 0, 0));
    directed.push_back(row(12'd400, 12'd0, 0, 0, 0, 0));
    directed.push_back(row(12'd40, 12'd30, 0, 0, 0, 0));
    foreach (directed[i]) begin
      if (directed[i].has_exp) begin
        typed = tunnel_coords(directed[i].x, directed[i].y);
        if (typed !== directed[i].exp_res) begin
          $display("%0t directed row %0d exp %h model %h", $time, i,
                   directed[i].exp_res, typed);
          fail_count++;
        end
      end
      send_request(directed[i].x, directed[i].y, 0);
    end
    drain();

    random_phase(200);
    // Hold off until the pipeline is empty
    drain();

    // Extremes: maximum depth constant and pans, thresholds at the top
    write_reg(REG_DEPTH_SCALE, 31'h7FFFFFFF);
    write_reg(REG_ANGLE_PAN, 31'h7FFFFFFF);
    write_reg(REG_DEPTH_PAN, 31'h00FFFFFF);
    write_reg(REG_BAND_NEAR, 31'h7FFFFFFF);
    write_reg(REG_BAND_SECOND, 31'h7FFFFFFF);
    write_reg(REG_BAND_THIRD, 31'h7FFFFFFF);
    write_reg(REG_BAND_FOURTH, 31'h7FFFFFFF);
    write_reg(REG_CORE_LIMIT, 31'h7FFFFFFF);
    random_phase(120);
    drain();

    // Extremes: everything zero, so every depth is zero and shades as near
    write_reg(REG_DEPTH_SCALE, 31'd0);
    write_reg(REG_ANGLE_PAN, 31'd0);
    write_reg(REG_DEPTH_PAN, 31'd0);
    write_reg(REG_BAND_NEAR, 31'd0);
    write_reg(REG_BAND_SECOND, 31'd0);
    write_reg(REG_BAND_THIRD, 31'd0);
    write_reg(REG_BAND_FOURTH, 31'd0);
    write_reg(REG_CORE_LIMIT, 31'd0);
    random_phase(60);
    drain();

    // Random settings, with the bands spread over rising ranges
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_DEPTH_SCALE, 31'($urandom));
      write_reg(REG_ANGLE_PAN, 31'($urandom));
      write_reg(REG_DEPTH_PAN, 31'($urandom));
      write_reg(REG_BAND_NEAR, 31'($urandom_range(0, 2000000)));
      write_reg(REG_BAND_SECOND, 31'($urandom_range(2000000, 5000000)));
      write_reg(REG_BAND_THIRD, 31'($urandom_range(5000000, 20000000)));
      write_reg(REG_BAND_FOURTH, 31'($urandom_range(20000000, 80000000)));
      write_reg(REG_CORE_LIMIT, 31'($urandom_range(0, 200000000)));
      random_phase(95);
      drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ptc_pkg.sv
sv/ptc_atan_cell.sv
sv/ptc_sqrt_cell.sv
sv/ptc_depth_cell.sv
sv/polar_texture_coordinate.sv
sv/ptc_checker.sv
bench/tb.sv
